// File: rtl/cbwe_pkg.sv
// Shared types, constants and register indexes of the cassette byte waveform encoder.
package cbwe_pkg;

    localparam int CountBits = 16;
    localparam int ValueW    = 16;
    localparam int LevelW    = 8;
    localparam int FrameW    = 12;
    localparam int BitsLeftW = 4;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 8;
    localparam int StopW     = 2;

    localparam logic [CfgIdxW-1:0] REG_LEVEL_HIGH     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_LEVEL_LOW      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_LEVEL_IDLE     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SHORT_HALF_LEN = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_LONG_HALF_LEN  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_STOP_BIT_COUNT = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_BYTE    = 2'd1,
        MODE_LEADER  = 2'd2,
        MODE_SILENCE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK         = 2'd0,
        OP_LOAD_BYTE    = 2'd1,
        OP_LOAD_LEADER  = 2'd2,
        OP_LOAD_SILENCE = 2'd3
    } op_t;

    typedef struct packed {
        logic [LevelW-1:0] level_high;
        logic [LevelW-1:0] level_low;
        logic [LevelW-1:0] level_idle;
        logic [LevelW-1:0] short_half_len;
        logic [LevelW-1:0] long_half_len;
        logic [StopW-1:0]  stop_bit_count;
    } cfg_t;

    typedef struct packed {
        mode_t                mode;
        logic [FrameW-1:0]    frame_bits;
        logic [BitsLeftW-1:0] bits_left;
        logic [CountBits-1:0] run_left;
        logic [7:0]           half_cnt;
        logic [1:0]           half_idx;
    } state_t;

    typedef struct packed {
        logic              rejected;
        logic              busy_res;
        logic              sample_valid;
        logic [LevelW-1:0] sample;
    } result_t;

endpackage

// File: rtl/cassette_byte_waveform_encoder_unit.sv
// Top level of the cassette byte waveform encoder: config registers, state and result register.

// Every command beat (tick or load) yields exactly one result beat. The block takes one
// command per clock cycle; the result appears in the output register in the cycle after the
// command is accepted, and s_tready stays high as long as that register is empty or being
// drained, so the only limit on rate is the consumer's m_tready. Tick samples are formed
// from the levels and half-period lengths in force at that cycle; loads arriving while a
// frame or run is in progress come back with the rejected flag and change nothing.
module cassette_byte_waveform_encoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // value[15:0]
    input  logic [1:0]                        s_tuser,   // op[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // sample[7:0]
    output logic [2:0]                        m_tuser,   // rejected, busy_res, sample_valid
    input  logic                              cfg_wr_en,
    input  logic [cbwe_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [cbwe_pkg::CfgDataW-1:0]     cfg_wdata
);

    cbwe_pkg::cfg_t    cfg_reg;
    cbwe_pkg::state_t  state_reg;
    cbwe_pkg::state_t  state_next;
    cbwe_pkg::result_t out_next;
    cbwe_pkg::result_t out_reg;
    logic              m_tvalid_reg;
    logic              in_beat;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    cbwe_step u_step (
        .op         (cbwe_pkg::op_t'(s_tuser)),
        .value      (s_tdata),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_high     <= 8'd255;
            cfg_reg.level_low      <= 8'd0;
            cfg_reg.level_idle     <= 8'd128;
            cfg_reg.short_half_len <= 8'd5;
            cfg_reg.long_half_len  <= 8'd10;
            cfg_reg.stop_bit_count <= 2'd2;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cbwe_pkg::REG_LEVEL_HIGH:     cfg_reg.level_high     <= cfg_wdata;
                cbwe_pkg::REG_LEVEL_LOW:      cfg_reg.level_low      <= cfg_wdata;
                cbwe_pkg::REG_LEVEL_IDLE:     cfg_reg.level_idle     <= cfg_wdata;
                cbwe_pkg::REG_SHORT_HALF_LEN: cfg_reg.short_half_len <= cfg_wdata;
                cbwe_pkg::REG_LONG_HALF_LEN:  cfg_reg.long_half_len  <= cfg_wdata;
                cbwe_pkg::REG_STOP_BIT_COUNT: cfg_reg.stop_bit_count <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode       <= cbwe_pkg::MODE_IDLE;
            state_reg.frame_bits <= '0;
            state_reg.bits_left  <= '0;
            state_reg.run_left   <= '0;
            state_reg.half_cnt   <= '0;
            state_reg.half_idx   <= '0;
            m_tvalid_reg         <= 1'b0;
        end else if (in_beat) begin
            state_reg    <= state_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.sample;
    assign m_tuser  = {out_reg.rejected, out_reg.busy_res, out_reg.sample_valid};

`ifndef SYNTHESIS
    a_reject_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.rejected |-> out_reg.busy_res && !out_reg.sample_valid)
        else $error("rejected result without busy flag or with a sample");

    a_byte_has_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode == cbwe_pkg::MODE_BYTE |-> state_reg.bits_left != '0)
        else $error("byte frame active with no bits left");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == cbwe_pkg::MODE_LEADER || state_reg.mode == cbwe_pkg::MODE_SILENCE)
        |-> state_reg.run_left != '0)
        else $error("run active with zero count");

    a_zero_bit_halves: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode == cbwe_pkg::MODE_BYTE && !state_reg.frame_bits[0]
        |-> state_reg.half_idx < 2'd2)
        else $error("zero bit beyond its second half period");

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> m_tvalid_reg && (out_reg.busy_res == (state_reg.mode != cbwe_pkg::MODE_IDLE)))
        else $error("result missing or busy flag disagrees with state");
`endif

endmodule

// File: rtl/cbwe_step.sv
// Next-state and result logic for one command beat of the waveform encoder.
module cbwe_step (
    input  cbwe_pkg::op_t                  op,
    input  logic [cbwe_pkg::ValueW-1:0]    value,
    input  cbwe_pkg::cfg_t                 cfg,
    input  cbwe_pkg::state_t               state,
    output cbwe_pkg::state_t               state_next,
    output cbwe_pkg::result_t              result
);

    logic                              cur_bit;
    logic [cbwe_pkg::LevelW-1:0]       half_len_raw;
    logic [cbwe_pkg::LevelW-1:0]       half_len;
    logic [7:0]                        half_cnt_inc;
    logic [1:0]                        half_idx_inc;
    logic                              bit_done;
    logic [cbwe_pkg::CountBits-1:0]    run_dec;
    logic [cbwe_pkg::StopW-1:0]        stops;
    logic [2:0]                        stop_ones;
    logic [cbwe_pkg::CountBits-1:0]    run_load;

    assign cur_bit      = (state.mode == cbwe_pkg::MODE_LEADER) ? 1'b1 : state.frame_bits[0];
    assign half_len_raw = cur_bit ? cfg.short_half_len : cfg.long_half_len;
    assign half_len     = (half_len_raw == '0) ? 8'd1 : half_len_raw;
    assign half_cnt_inc = state.half_cnt + 8'd1;
    assign half_idx_inc = state.half_idx + 2'd1;
    // A one bit ends after four half periods (index wraps), a zero bit after two.
    assign bit_done     = (half_idx_inc == 2'd0) || (!cur_bit && half_idx_inc >= 2'd2);
    assign run_dec      = state.run_left - {{(cbwe_pkg::CountBits-1){1'b0}}, 1'b1};
    assign stops        = (cfg.stop_bit_count == '0) ? 2'd1 : cfg.stop_bit_count;
    assign stop_ones    = (stops == 2'd1) ? 3'b001 : ((stops == 2'd2) ? 3'b011 : 3'b111);
    assign run_load     = cbwe_pkg::CountBits'(value);

    always_comb begin
        state_next = state;
        result     = '0;
        if (op == cbwe_pkg::OP_TICK) begin
            result.sample_valid = 1'b1;
            unique case (state.mode)
                cbwe_pkg::MODE_IDLE: begin
                    result.sample = cfg.level_idle;
                end
                cbwe_pkg::MODE_SILENCE: begin
                    result.sample       = cfg.level_idle;
                    state_next.run_left = run_dec;
                    if (run_dec == '0) begin
                        state_next.mode = cbwe_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    result.sample       = state.half_idx[0] ? cfg.level_low : cfg.level_high;
                    state_next.half_cnt = half_cnt_inc;
                    if (half_cnt_inc >= half_len) begin
                        state_next.half_cnt = 8'd0;
                        state_next.half_idx = half_idx_inc;
                        if (bit_done) begin
                            state_next.half_idx = 2'd0;
                            if (state.mode == cbwe_pkg::MODE_BYTE) begin
                                state_next.frame_bits = state.frame_bits >> 1;
                                state_next.bits_left  = state.bits_left - 4'd1;
                                if (state.bits_left == 4'd1) begin
                                    state_next.mode = cbwe_pkg::MODE_IDLE;
                                end
                            end else begin
                                state_next.run_left = run_dec;
                                if (run_dec == '0) begin
                                    state_next.mode = cbwe_pkg::MODE_IDLE;
                                end
                            end
                        end
                    end
                end
            endcase
        end else if (state.mode != cbwe_pkg::MODE_IDLE) begin
            result.rejected = 1'b1;
        end else begin
            state_next.half_cnt = 8'd0;
            state_next.half_idx = 2'd0;
            if (op == cbwe_pkg::OP_LOAD_BYTE) begin
                state_next.frame_bits = {stop_ones, value[7:0], 1'b0};
                state_next.bits_left  = 4'd9 + {2'b00, stops};
                state_next.mode       = cbwe_pkg::MODE_BYTE;
            end else begin
                state_next.run_left = run_load;
                if (run_load == '0) begin
                    state_next.mode = cbwe_pkg::MODE_IDLE;
                end else if (op == cbwe_pkg::OP_LOAD_LEADER) begin
                    state_next.mode = cbwe_pkg::MODE_LEADER;
                end else begin
                    state_next.mode = cbwe_pkg::MODE_SILENCE;
                end
            end
        end
        result.busy_res = (state_next.mode != cbwe_pkg::MODE_IDLE);
    end

endmodule
